// ----- hdl/g2mi_pkg.sv -----
// Shared transaction types for the GF(2^m) 2x2 matrix inverse block.
// Holds the request and response payload structs; depends on nothing.
package g2mi_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int DEGREE_W = 4;
   localparam int POLY_W   = 9;
   localparam int ELEM_W   = 8;

   typedef struct packed {
      logic [DEGREE_W-1:0] degree;
      logic [POLY_W-1:0]   reduce_poly;
      logic [ELEM_W-1:0]   elem_a;
      logic [ELEM_W-1:0]   elem_b;
      logic [ELEM_W-1:0]   elem_c;
      logic [ELEM_W-1:0]   elem_d;
   } req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] inv_00;
      logic [ELEM_W-1:0] inv_01;
      logic [ELEM_W-1:0] inv_10;
      logic [ELEM_W-1:0] inv_11;
   } rsp_type;

endpackage

// ----- hdl/g2mi_mul_step.sv -----
// One Horner step of a bit-serial GF(2^m) multiplier, MSB of the multiplier first.
// Purely combinational; depends on no package.
module g2mi_mul_step #(
   parameter int W = 8
) (
   input  logic [W-1:0]         acc_i,
   input  logic [W-1:0]         addend_i,
   input  logic                 bit_i,
   input  logic [W:0]           poly_i,
   input  logic [$clog2(W)-1:0] msb_i,
   output logic [W-1:0]         acc_o
);

   logic         ovf;
   logic [W:0]   shifted;

   // Doubling modulo the polynomial: the top term cancels against bit m of the polynomial.
   always_comb begin
      ovf     = acc_i[msb_i];
      shifted = {acc_i, 1'b0} ^ (ovf ? poly_i : '0);
      acc_o   = shifted[W-1:0] ^ (bit_i ? addend_i : '0);
   end

endmodule

// ----- hdl/g2mi_euclid_step.sv -----
// One step of the shift-and-xor extended Euclidean algorithm over GF(2)[x].
// Purely combinational; depends on no package.
module g2mi_euclid_step #(
   parameter int W = 8
) (
   input  logic [W:0] r0_i,
   input  logic [W:0] r1_i,
   input  logic [W:0] s0_i,
   input  logic [W:0] s1_i,
   output logic [W:0] r0_o,
   output logic [W:0] r1_o,
   output logic [W:0] s0_o,
   output logic [W:0] s1_o
);

   localparam int MW = $clog2(W + 1);

   logic [MW-1:0] deg0;
   logic [MW-1:0] deg1;
   logic [MW-1:0] sh;
   logic          swap;

   // Leading-term positions of both remainders.
   always_comb begin
      deg0 = '0;
      deg1 = '0;
      for (int i = 0; i <= W; i++) begin
         if (r0_i[i]) deg0 = MW'(i);
         if (r1_i[i]) deg1 = MW'(i);
      end
   end

   // Swap when the first remainder is the smaller one, otherwise cancel its top term.
   always_comb begin
      swap = (r0_i == '0) || (deg0 < deg1);
      sh   = deg0 - deg1;
      if (swap) begin
         r0_o = r1_i;
         r1_o = r0_i;
         s0_o = s1_i;
         s1_o = s0_i;
      end else begin
         r0_o = r0_i ^ (r1_i << sh);
         r1_o = r1_i;
         s0_o = s0_i ^ (s1_i << sh);
         s1_o = s1_i;
      end
   end

endmodule

// ----- hdl/gf2m_matrix2x2_inverse_top.sv -----
// Inverts a 2x2 matrix over GF(2^m) with one shared bit-serial field multiplier.
// After the accepting edge it forms the two determinant products, runs one Euclid step at a
// time until the second remainder is zero plus a finishing step, then the four output products;
// a singular matrix skips the last two. The response then holds until it is accepted.
// One transaction at a time; a new request can be taken in the cycle after the response
// leaves. Reset is synchronous and active high; it returns the sequencer to idle.
module gf2m_matrix2x2_inverse_top #(
   parameter int MAX_DEGREE = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  g2mi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output g2mi_pkg::rsp_type rsp_data
);

   import g2mi_pkg::*;

   localparam int W  = MAX_DEGREE;
   localparam int MW = $clog2(W + 1);
   localparam int IW = $clog2(W);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_INV  = 3'd3;
   localparam logic [2:0] ST_MULO = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   // Output slot order, following the response fields.
   localparam logic [1:0] SLOT_00 = 2'd0;
   localparam logic [1:0] SLOT_01 = 2'd1;
   localparam logic [1:0] SLOT_10 = 2'd2;
   localparam logic [1:0] SLOT_11 = 2'd3;

   logic [2:0]    state_ff, state_in;
   logic [MW-1:0] m_ff, m_in;
   logic [W:0]    poly_ff, poly_in;
   logic [W-1:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  det_ff, det_in;
   logic [W-1:0]  inv_ff, inv_in;
   logic [W:0]    r0_ff, r0_in, r1_ff, r1_in, s0_ff, s0_in, s1_ff, s1_in;
   logic [1:0]    k_ff, k_in;
   rsp_type       rsp_ff, rsp_in;

   logic [MW-1:0] m_req;
   logic [W-1:0]  mask_req;
   logic [W:0]    poly_ext;
   logic [W:0]    poly_req;
   logic [IW-1:0] msb;
   logic [W-1:0]  mul_addend;
   logic          mul_bit;
   logic [W-1:0]  mul_acc;
   logic [W-1:0]  det_sum;
   logic [W:0]    s0_red;
   logic [W:0]    r0_step, r1_step, s0_step, s1_step;
   logic [ELEM_W-1:0] field_out;

   // Clamp the degree and build the element mask and the reduction polynomial.
   always_comb begin
      if (req_data.degree < DEGREE_W'(2)) begin
         m_req = MW'(2);
      end else if (int'(req_data.degree) > W) begin
         m_req = MW'(W);
      end else begin
         m_req = MW'(req_data.degree);
      end
      poly_ext = (W + 1)'(req_data.reduce_poly);
      for (int i = 0; i < W; i++) begin
         mask_req[i] = (i < int'(m_req));
      end
      for (int i = 0; i <= W; i++) begin
         poly_req[i] = (i < int'(m_req)) ? poly_ext[i] : (i == int'(m_req));
      end
   end

   assign msb = IW'(m_ff - MW'(1));

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_addend = a_ff;
      mul_bit    = d_ff[cnt_ff];
      case (state_ff)
         ST_MUL2: begin
            mul_addend = b_ff;
            mul_bit    = c_ff[cnt_ff];
         end
         ST_MULO: begin
            mul_bit = inv_ff[cnt_ff];
            case (k_ff)
               SLOT_00: mul_addend = d_ff;
               SLOT_01: mul_addend = b_ff;
               SLOT_10: mul_addend = c_ff;
               SLOT_11: mul_addend = a_ff;
               default: mul_addend = a_ff;
            endcase
         end
         default: begin
            mul_addend = a_ff;
            mul_bit    = d_ff[cnt_ff];
         end
      endcase
   end

   g2mi_mul_step #(.W(W)) u_mul (
      .acc_i    (acc_ff),
      .addend_i (mul_addend),
      .bit_i    (mul_bit),
      .poly_i   (poly_ff),
      .msb_i    (msb),
      .acc_o    (mul_acc)
   );

   g2mi_euclid_step #(.W(W)) u_euclid (
      .r0_i (r0_ff),
      .r1_i (r1_ff),
      .s0_i (s0_ff),
      .s1_i (s1_ff),
      .r0_o (r0_step),
      .r1_o (r1_step),
      .s0_o (s0_step),
      .s1_o (s1_step)
   );

   // Final reduction of the Bezout coefficient and the narrowed product.
   assign det_sum   = det_ff ^ mul_acc;
   assign s0_red    = s0_ff[m_ff] ? (s0_ff ^ poly_ff) : s0_ff;
   assign field_out = ELEM_W'(mul_acc);

   // Sequencer: load, two determinant products, Euclid loop, four output products.
   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      poly_in  = poly_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      det_in   = det_ff;
      inv_in   = inv_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      s0_in    = s0_ff;
      s1_in    = s1_ff;
      k_in     = k_ff;
      rsp_in   = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               m_in     = m_req;
               poly_in  = poly_req;
               a_in     = W'(req_data.elem_a) & mask_req;
               b_in     = W'(req_data.elem_b) & mask_req;
               c_in     = W'(req_data.elem_c) & mask_req;
               d_in     = W'(req_data.elem_d) & mask_req;
               acc_in   = '0;
               cnt_in   = IW'(m_req - MW'(1));
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            acc_in = mul_acc;
            cnt_in = cnt_ff - IW'(1);
            if (cnt_ff == '0) begin
               det_in   = mul_acc;
               acc_in   = '0;
               cnt_in   = msb;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            acc_in = mul_acc;
            cnt_in = cnt_ff - IW'(1);
            if (cnt_ff == '0) begin
               if (det_sum == '0) begin
                  rsp_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  r0_in    = poly_ff;
                  r1_in    = {1'b0, det_sum};
                  s0_in    = '0;
                  s1_in    = (W + 1)'(1);
                  state_in = ST_INV;
               end
            end
         end
         ST_INV: begin
            if (r1_ff == '0) begin
               if (r0_ff == (W + 1)'(1)) begin
                  inv_in   = s0_red[W-1:0];
                  acc_in   = '0;
                  cnt_in   = msb;
                  k_in     = SLOT_00;
                  state_in = ST_MULO;
               end else begin
                  // Reducible polynomial sharing a factor with det: no inverse.
                  rsp_in   = '0;
                  state_in = ST_DONE;
               end
            end else begin
               r0_in = r0_step;
               r1_in = r1_step;
               s0_in = s0_step;
               s1_in = s1_step;
            end
         end
         ST_MULO: begin
            acc_in = mul_acc;
            cnt_in = cnt_ff - IW'(1);
            if (cnt_ff == '0) begin
               case (k_ff)
                  SLOT_00: rsp_in.inv_00 = field_out;
                  SLOT_01: rsp_in.inv_01 = field_out;
                  SLOT_10: rsp_in.inv_10 = field_out;
                  SLOT_11: rsp_in.inv_11 = field_out;
                  default: rsp_in.inv_11 = field_out;
               endcase
               acc_in = '0;
               cnt_in = msb;
               k_in   = k_ff + 2'd1;
               if (k_ff == SLOT_11) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      poly_ff <= poly_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      det_ff  <= det_in;
      inv_ff  <= inv_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      s0_ff   <= s0_in;
      s1_ff   <= s1_in;
      k_ff    <= k_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/g2mi_checker.sv -----
// Port-level checks for the GF(2^m) 2x2 matrix inverse top level, with its bind.
// Depends on g2mi_pkg and gf2m_matrix2x2_inverse_top.
module g2mi_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input g2mi_pkg::rsp_type rsp_data
);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // The block never offers a response while it takes a request.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a response is pending");

   // An accepted request makes the block busy in the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("block not busy after accepting a request");

   // A delivered response frees the block for the next request.
   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("block not idle after delivering a response");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind gf2m_matrix2x2_inverse_top g2mi_checker u_g2mi_checker (.*);

// ----- dv/gf2m_matrix2x2_inverse_checker.sv -----
// Response checker for the GF(2^m) 2x2 matrix inverse block.
// Watches both channels, predicts each inverse and compares it; uses g2mi_pkg.
module gf2m_matrix2x2_inverse_checker #(
   parameter int MAX_DEGREE = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  g2mi_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  g2mi_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                outstanding
);

   import g2mi_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // One accepted request together with the inverse it must produce.
   typedef struct packed {
      req_type stim;
      rsp_type inverse;
   } inverse_entry_type;

   inverse_entry_type inverse_queue[$];

   // Index of the highest set bit, or -1 for zero.
   function automatic int top_bit(logic [31:0] x);
      int d;
      d = -1;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) d = i;
      end
      return d;
   endfunction

   // Reduces a product of two field elements modulo the polynomial.
   function automatic logic [31:0] field_reduce(logic [31:0] x, logic [31:0] p, int m);
      for (int i = 2 * m - 1; i >= m; i--) begin
         if (x[i]) x = x ^ (p << (i - m));
      end
      return x;
   endfunction

   // Carry-less multiply followed by reduction.
   function automatic logic [31:0] field_mul(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] p, int m);
      logic [31:0] acc;
      acc = '0;
      for (int i = 0; i < m; i++) begin
         if (b[i]) acc = acc ^ (a << i);
      end
      return field_reduce(acc, p, m);
   endfunction

   // Extended Euclid by shift and xor; ok is cleared when gcd(x, p) is not one.
   function automatic logic [31:0] field_inverse(logic [31:0] x, logic [31:0] p, int m,
                                                 output bit ok);
      logic [31:0] r0, r1, s0, s1, t;
      int sh;
      r0 = p;
      r1 = x;
      s0 = '0;
      s1 = 32'd1;
      while (r1 != 0) begin
         sh = top_bit(r0) - top_bit(r1);
         if (sh < 0) begin
            t = r0; r0 = r1; r1 = t;
            t = s0; s0 = s1; s1 = t;
         end else begin
            r0 = r0 ^ (r1 << sh);
            s0 = s0 ^ (s1 << sh);
         end
      end
      ok = (r0 == 32'd1);
      return field_reduce(s0 & ((32'd1 << (m + 1)) - 32'd1), p, m);
   endfunction

   // Expected inverse matrix for one request; zeros when det has no inverse.
   function automatic rsp_type predict_inverse(req_type stim);
      int m;
      logic [31:0] mask, p, a, b, c, d, det, inv;
      bit ok;
      rsp_type result;
      m = int'(stim.degree);
      if (m < 2) m = 2;
      if (m > MAX_DEGREE) m = MAX_DEGREE;
      mask = (32'd1 << m) - 32'd1;
      p = ({23'd0, stim.reduce_poly} & mask) | (32'd1 << m);
      a = {24'd0, stim.elem_a} & mask;
      b = {24'd0, stim.elem_b} & mask;
      c = {24'd0, stim.elem_c} & mask;
      d = {24'd0, stim.elem_d} & mask;
      det = field_mul(a, d, p, m) ^ field_mul(b, c, p, m);
      ok = 1'b0;
      inv = '0;
      if (det != 0) inv = field_inverse(det, p, m, ok);
      result = '0;
      if (ok) begin
         result.inv_00 = ELEM_W'(field_mul(d, inv, p, m));
         result.inv_01 = ELEM_W'(field_mul(b, inv, p, m));
         result.inv_10 = ELEM_W'(field_mul(c, inv, p, m));
         result.inv_11 = ELEM_W'(field_mul(a, inv, p, m));
      end
      return result;
   endfunction

   // Record each accepted request, then match each accepted response with the oldest one.
   always @(posedge clock) begin : monitor
      inverse_entry_type entry;
      inverse_entry_type head;
      if (reset) begin
         mismatch_count = 0;
         outstanding = 0;
      end else begin
         if (req_valid && req_ready) begin
            entry.stim = req_data;
            entry.inverse = predict_inverse(req_data);
            inverse_queue.push_back(entry);
         end
         if (rsp_valid && rsp_ready) begin
            if (inverse_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected response transaction %02h %02h %02h %02h",
                           rsp_data.inv_00, rsp_data.inv_01, rsp_data.inv_10,
                           rsp_data.inv_11);
               end
            end else begin
               head = inverse_queue.pop_front();
               if (rsp_data.inv_00 !== head.inverse.inv_00 ||
                   rsp_data.inv_01 !== head.inverse.inv_01 ||
                   rsp_data.inv_10 !== head.inverse.inv_10 ||
                   rsp_data.inv_11 !== head.inverse.inv_11) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display({"mismatch: deg %0d poly %03h a %02h b %02h c %02h d %02h",
                               " got %02h %02h %02h %02h expected %02h %02h %02h %02h"},
                              head.stim.degree, head.stim.reduce_poly, head.stim.elem_a,
                              head.stim.elem_b, head.stim.elem_c, head.stim.elem_d,
                              rsp_data.inv_00, rsp_data.inv_01, rsp_data.inv_10,
                              rsp_data.inv_11, head.inverse.inv_00, head.inverse.inv_01,
                              head.inverse.inv_10, head.inverse.inv_11);
                  end
               end
            end
         end
         outstanding = inverse_queue.size();
      end
   end

endmodule

// ----- dv/tb_gf2m_matrix2x2_inverse_top.sv -----
// Testbench top for the GF(2^m) 2x2 matrix inverse block: clock, reset, stimulus, verdict.
// Depends on g2mi_pkg, gf2m_matrix2x2_inverse_top and gf2m_matrix2x2_inverse_checker.
module tb_gf2m_matrix2x2_inverse_top;

   import g2mi_pkg::*;

   localparam int MAX_DEGREE   = 8;
   localparam int N_RANDOM     = 1850;
   localparam int CALM_TAIL    = 250;
   localparam int HOLD_AT      = 500;
   localparam int PAUSE_AT     = 900;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 100;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      mismatch_count;
   int      outstanding;
   int      idle_cycles = 0;
   bit      long_hold_go = 1'b0;
   bit      calm = 1'b0;
   req_type directed[$];

   always #5 clock = ~clock;

   gf2m_matrix2x2_inverse_top #(
      .MAX_DEGREE(MAX_DEGREE)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   gf2m_matrix2x2_inverse_checker #(
      .MAX_DEGREE(MAX_DEGREE)
   ) inverse_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   function automatic req_type make_request(int deg, int poly, int a, int b, int c, int d);
      req_type item;
      item.degree = DEGREE_W'(deg);
      item.reduce_poly = POLY_W'(poly);
      item.elem_a = ELEM_W'(a);
      item.elem_b = ELEM_W'(b);
      item.elem_c = ELEM_W'(c);
      item.elem_d = ELEM_W'(d);
      return item;
   endfunction

   // One to four irreducible polynomials for each degree, with the top term included.
   function automatic logic [8:0] irreducible_poly(int m, logic [1:0] k);
      logic [8:0] choices[4];
      case (m)
         2: choices = '{9'h007, 9'h007, 9'h007, 9'h007};
         3: choices = '{9'h00B, 9'h00D, 9'h00B, 9'h00D};
         4: choices = '{9'h013, 9'h019, 9'h01F, 9'h013};
         5: choices = '{9'h025, 9'h029, 9'h02F, 9'h037};
         6: choices = '{9'h043, 9'h049, 9'h057, 9'h05B};
         7: choices = '{9'h083, 9'h089, 9'h08F, 9'h09D};
         default: choices = '{9'h11B, 9'h11D, 9'h12B, 9'h139};
      endcase
      return choices[k];
   endfunction

   // Mostly well-formed matrices over a proper field, the rest raw noise on every bit.
   function automatic req_type random_request();
      req_type item;
      int m;
      logic [7:0] mask;
      if ($urandom_range(0, 9) < 7) begin
         m = $urandom_range(2, 8);
         mask = ELEM_W'((9'd1 << m) - 9'd1);
         item.degree = DEGREE_W'(m);
         item.reduce_poly = irreducible_poly(m, 2'($urandom_range(0, 3)));
         item.elem_a = ELEM_W'($urandom) & mask;
         item.elem_b = ELEM_W'($urandom) & mask;
         item.elem_c = ELEM_W'($urandom) & mask;
         item.elem_d = ELEM_W'($urandom) & mask;
         // Repeating the first row gives a singular matrix.
         if ($urandom_range(0, 9) == 0) begin
            item.elem_c = item.elem_a;
            item.elem_d = item.elem_b;
         end
      end else begin
         item.degree = DEGREE_W'($urandom);
         item.reduce_poly = POLY_W'($urandom);
         item.elem_a = ELEM_W'($urandom);
         item.elem_b = ELEM_W'($urandom);
         item.elem_c = ELEM_W'($urandom);
         item.elem_d = ELEM_W'($urandom);
      end
      return item;
   endfunction

   // Offer one request transaction and hold it until it is accepted.
   task automatic send_transaction(input req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random burst of idle cycles on the request side.
   task automatic sender_gap();
      if (!calm && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
   endtask

   // Stop offering until every expected response has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Response side: random stalls, one long hold-off on request, none near the end.
   initial begin : receiver
      bit long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      // Identity, extremes, clamped degrees, ignored bits, singular and non-invertible cases.
      directed.push_back(make_request(2, 9'h007, 1, 0, 0, 1));
      directed.push_back(make_request(2, 9'h007, 3, 2, 1, 3));
      directed.push_back(make_request(8, 9'h11B, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      directed.push_back(make_request(8, 9'h11B, 8'h53, 0, 0, 8'hCA));
      directed.push_back(make_request(8, 9'h11D, 8'h80, 1, 1, 8'h80));
      directed.push_back(make_request(8, 9'h11B, 8'hFF, 0, 0, 8'hFE));
      directed.push_back(make_request(0, 9'h1FF, 8'hFF, 8'h02, 8'h01, 8'hFE));
      directed.push_back(make_request(1, 9'h007, 2, 1, 1, 3));
      directed.push_back(make_request(9, 9'h000, 8'h12, 8'h34, 8'h56, 8'h78));
      directed.push_back(make_request(15, 9'h100, 8'hA5, 8'h5A, 8'hC3, 8'h3C));
      directed.push_back(make_request(0, 9'h000, 0, 0, 0, 0));
      directed.push_back(make_request(4, 9'h1F3, 8'h09, 8'h0E, 8'h07, 8'h0B));
      directed.push_back(make_request(3, 9'h00B, 8'hF9, 8'hAE, 8'h33, 8'hC4));
      directed.push_back(make_request(4, 9'h011, 3, 0, 0, 1));
      directed.push_back(make_request(4, 9'h011, 2, 0, 0, 1));
      directed.push_back(make_request(5, 9'h025, 8'h1F, 8'h11, 8'h0A, 8'h15));
      directed.push_back(make_request(6, 9'h043, 8'h3F, 8'h20, 8'h01, 8'h2A));
      directed.push_back(make_request(7, 9'h083, 8'h55, 8'h7F, 8'h55, 8'h7F));
      directed.push_back(make_request(8, 9'h01B, 8'h02, 8'h03, 8'h04, 8'h05));
      directed.push_back(make_request(8, 9'h11B, 0, 0, 0, 0));

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_transaction(directed[i]);
         sender_gap();
      end
      wait_for_drain();

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == HOLD_AT) long_hold_go = 1'b1;
         if (i == PAUSE_AT) wait_for_drain();
         if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;
         send_transaction(random_request());
         sender_gap();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Let the last responses arrive, then allow time for any stray one.
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
